// ----- src/cau_pkg.sv -----
// Shared types, opcodes and saturation helpers for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

	// Fixed-point format and unit depths.
	localparam int FRAC_BITS  = 16;
	localparam int WORD_BITS  = 32;
	localparam int DIV_STEPS  = 32;
	localparam int SQRT_STEPS = 32;

	typedef logic signed [WORD_BITS-1:0] word_t;

	// Opcodes carried by the kind field.
	typedef enum logic [3:0] {
		OP_ADD    = 4'd0,
		OP_SUB    = 4'd1,
		OP_MUL    = 4'd2,
		OP_DIV    = 4'd3,
		OP_SCALE  = 4'd4,
		OP_CONJ   = 4'd5,
		OP_NEG    = 4'd6,
		OP_MAG    = 4'd7,
		OP_MAGSQ  = 4'd8,
		OP_ISZERO = 4'd9,
		OP_ISEQ   = 4'd10,
		OP_ISNEAR = 4'd11
	} op_t;

	// Per-item data that travels beside the divider and root pipelines.
	typedef struct packed {
		logic [3:0] kind;
		word_t      re;
		word_t      im;
		logic       flag;
		logic       re_neg;
		logic       im_neg;
		logic       den_zero;
	} side_t;

	// One finished result.
	typedef struct packed {
		word_t re;
		word_t im;
		logic  flag;
	} res_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// Saturate a wide signed value to the word range.
	function automatic word_t sat_wide(input logic signed [65:0] v);
		word_t r;
		if (v > 66'(WORD_MAX)) begin
			r = WORD_MAX;
		end else if (v < 66'(WORD_MIN)) begin
			r = WORD_MIN;
		end else begin
			r = v[WORD_BITS-1:0];
		end
		return r;
	endfunction

	// Drop the fraction bits rounding toward minus infinity, then saturate.
	function automatic word_t sat_floor(input logic signed [65:0] v);
		logic signed [65:0] s;
		s = v >>> FRAC_BITS;
		return sat_wide(s);
	endfunction

	// Apply the sign to a truncated quotient magnitude and saturate.
	function automatic word_t div_sat(input logic [WORD_BITS-1:0] q, input logic ovf,
			input logic neg);
		word_t r;
		if (neg) begin
			if (ovf || q > WORD_BITS'(WORD_MIN)) begin
				r = WORD_MIN;
			end else begin
				r = ~q + 1'b1;
			end
		end else begin
			if (ovf || q[WORD_BITS-1]) begin
				r = WORD_MAX;
			end else begin
				r = q;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/complex_arithmetic_unit.sv -----
// Top level of the pipelined complex-number ALU over signed Q16.16.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_stall  | kind, a_re, a_im, b_re, b_im, scale_factor,
//           |                      | tolerance
//   out     | out_valid / out_stall| result_re, result_im, result_flag
//
// One item enters per cycle while in_stall is low.
// The depth is set by the divider and square-root pipelines.
// Reset clears only valid bits and the output and skid flags.
// A stalled output parks one more result in a skid register; the pipeline
// then holds and in_stall stays high until the skid register drains.
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         kind,
	input  wire logic signed [31:0] a_re,
	input  wire logic signed [31:0] a_im,
	input  wire logic signed [31:0] b_re,
	input  wire logic signed [31:0] b_im,
	input  wire logic signed [31:0] scale_factor,
	input  wire logic [30:0]        tolerance,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      result_re,
	output logic signed [31:0]      result_im,
	output logic                    result_flag
);

	localparam int UNIT_DEPTH = DIV_STEPS + 1;

	logic adv;

	// Stage 1 registers.
	logic              v_s1;
	logic [3:0]        kind_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [63:0] p_fr_s1, p_fi_s1, p_aa_s1, p_bb_s1, p_cc_s1, p_dd_s1;
	word_t             re_s1, im_s1;
	logic              flag_s1;

	// Stage 2 registers.
	logic        v_s2;
	side_t       side_s2;
	logic [63:0] nre_s2, nim_s2, den_s2, msum_s2;

	// Side data alongside the divider and root stages.
	logic  vld_sn  [0:UNIT_DEPTH-1];
	side_t side_sn [0:UNIT_DEPTH-1];

	logic [31:0] q_re, q_im, root;
	logic        ovf_re, ovf_im;

	// Output and skid registers.
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q, fin;

	assign adv      = !skid_v_q;
	assign in_stall = skid_v_q;

	// Stage 1 combinational: simple results and comparisons.
	logic signed [32:0] dre, dim;
	logic [32:0]        adre, adim;
	word_t              re_c, im_c;
	logic               flag_c;

	always_comb begin
		dre    = 33'(a_re) - 33'(b_re);
		dim    = 33'(a_im) - 33'(b_im);
		adre   = dre[32] ? 33'(-dre) : 33'(dre);
		adim   = dim[32] ? 33'(-dim) : 33'(dim);
		re_c   = '0;
		im_c   = '0;
		flag_c = 1'b0;
		case (op_t'(kind))
			OP_ADD: begin
				re_c = sat_wide(66'(a_re) + 66'(b_re));
				im_c = sat_wide(66'(a_im) + 66'(b_im));
			end
			OP_SUB: begin
				re_c = sat_wide(66'(a_re) - 66'(b_re));
				im_c = sat_wide(66'(a_im) - 66'(b_im));
			end
			OP_CONJ: begin
				re_c = a_re;
				im_c = sat_wide(-66'(a_im));
			end
			OP_NEG: begin
				re_c = sat_wide(-66'(a_re));
				im_c = sat_wide(-66'(a_im));
			end
			OP_ISZERO: flag_c = (a_re == '0) && (a_im == '0);
			OP_ISEQ:   flag_c = (a_re == b_re) && (a_im == b_im);
			OP_ISNEAR: flag_c = (adre <= 33'(tolerance)) && (adim <= 33'(tolerance));
			default: begin
			end
		endcase
	end

	// Stage 1: all products and the simple results.
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			p_rr_s1 <= a_re * b_re;
			p_ii_s1 <= a_im * b_im;
			p_ri_s1 <= a_re * b_im;
			p_ir_s1 <= a_im * b_re;
			p_fr_s1 <= a_re * scale_factor;
			p_fi_s1 <= a_im * scale_factor;
			p_aa_s1 <= a_re * a_re;
			p_bb_s1 <= a_im * a_im;
			p_cc_s1 <= b_re * b_re;
			p_dd_s1 <= b_im * b_im;
			re_s1   <= re_c;
			im_s1   <= im_c;
			flag_s1 <= flag_c;
		end
	end

	// Stage 2 combinational: sums of products, shifted and saturated results.
	logic signed [65:0] num_re, num_im, den_w, msum_w;
	side_t              side_c;

	always_comb begin
		num_re = 66'(p_rr_s1) + 66'(p_ii_s1);
		num_im = 66'(p_ir_s1) - 66'(p_ri_s1);
		den_w  = 66'(p_cc_s1) + 66'(p_dd_s1);
		msum_w = 66'(p_aa_s1) + 66'(p_bb_s1);
		side_c.kind     = kind_s1;
		side_c.re       = re_s1;
		side_c.im       = im_s1;
		side_c.flag     = flag_s1;
		side_c.re_neg   = num_re[65];
		side_c.im_neg   = num_im[65];
		side_c.den_zero = den_w == '0;
		case (op_t'(kind_s1))
			OP_MUL: begin
				side_c.re = sat_floor(66'(p_rr_s1) - 66'(p_ii_s1));
				side_c.im = sat_floor(66'(p_ri_s1) + 66'(p_ir_s1));
			end
			OP_SCALE: begin
				side_c.re = sat_floor(66'(p_fr_s1));
				side_c.im = sat_floor(66'(p_fi_s1));
			end
			OP_MAGSQ: begin
				side_c.re = sat_floor(msum_w);
				side_c.im = '0;
			end
			default: begin
			end
		endcase
	end

	logic [65:0] nre_mag, nim_mag;
	assign nre_mag = num_re[65] ? 66'(-num_re) : 66'(num_re);
	assign nim_mag = num_im[65] ? 66'(-num_im) : 66'(num_im);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_c;
			nre_s2  <= nre_mag[63:0];
			nim_s2  <= nim_mag[63:0];
			den_s2  <= den_w[63:0];
			msum_s2 <= msum_w[63:0];
		end
	end

	// Long-latency units.
	cau_div u_div_re (
		.clk (clk),
		.adv (adv),
		.num (nre_s2),
		.den (den_s2),
		.quo (q_re),
		.ovf (ovf_re)
	);

	cau_div u_div_im (
		.clk (clk),
		.adv (adv),
		.num (nim_s2),
		.den (den_s2),
		.quo (q_im),
		.ovf (ovf_im)
	);

	cau_sqrt u_sqrt (
		.clk  (clk),
		.adv  (adv),
		.val  (msum_s2),
		.root (root)
	);

	// Side data delay line matching the unit depth.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_sn[0] <= side_s2;
			for (int k = 1; k < UNIT_DEPTH; k++) begin
				side_sn[k] <= side_sn[k-1];
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < UNIT_DEPTH; k++) begin
				vld_sn[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			vld_sn[0] <= v_s2;
			for (int k = 1; k < UNIT_DEPTH; k++) begin
				vld_sn[k] <= vld_sn[k-1];
			end
		end
	end

	// Final selection of divider and root results.
	side_t last;
	assign last = side_sn[UNIT_DEPTH-1];

	always_comb begin
		fin.re   = last.re;
		fin.im   = last.im;
		fin.flag = last.flag;
		case (op_t'(last.kind))
			OP_DIV: begin
				if (last.den_zero) begin
					fin.re = '0;
					fin.im = '0;
				end else begin
					fin.re = div_sat(q_re, ovf_re, last.re_neg);
					fin.im = div_sat(q_im, ovf_im, last.im_neg);
				end
			end
			OP_MAG: begin
				fin.re = root[31] ? WORD_MAX : word_t'(root);
				fin.im = '0;
			end
			default: begin
			end
		endcase
	end

	// Output register with a one-entry skid behind it.
	logic arrive;
	assign arrive = adv && vld_sn[UNIT_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && out_stall) begin
			if (arrive) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= arrive;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && out_stall) begin
			if (arrive) begin
				skid_q <= fin;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else if (arrive) begin
			out_q <= fin;
		end
	end

	assign out_valid   = out_v_q;
	assign result_re   = out_q.re;
	assign result_im   = out_q.im;
	assign result_flag = out_q.flag;

	// The skid register fills only behind a stalled output.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && out_stall))
		else $error("skid register filled while output was free");

	// An occupied skid register always has a result in front of it.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds an item with no output item");

	// Comparison answers carry zero numeric parts.
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.flag) |-> (out_q.re == '0 && out_q.im == '0))
		else $error("flagged result has nonzero numeric parts");

endmodule

`default_nettype wire

// ----- src/cau_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, fraction bits appended.
`default_nettype none

module cau_div import cau_pkg::*; (
	input  wire logic        clk,
	input  wire logic        adv,
	input  wire logic [63:0] num,
	input  wire logic [63:0] den,
	output logic [31:0]      quo,
	output logic             ovf
);

	logic [63:0]          r_s   [0:DIV_STEPS];
	logic [63:0]          d_s   [0:DIV_STEPS];
	logic [FRAC_BITS-1:0] lo_s  [0:DIV_STEPS];
	logic [31:0]          q_s   [0:DIV_STEPS];
	logic                 ovf_s [0:DIV_STEPS];

	// Setup stage: the quotient overflows 32 bits when num >= den * 2^16.
	always_ff @(posedge clk) begin
		if (adv) begin
			ovf_s[0] <= {16'b0, num} >= {den, 16'b0};
			r_s[0]   <= {16'b0, num[63:16]};
			lo_s[0]  <= num[FRAC_BITS-1:0];
			d_s[0]   <= den;
			q_s[0]   <= '0;
		end
	end

	// One shift, compare and subtract per stage.
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		localparam int I = DIV_STEPS - k;
		logic        xbit;
		logic [64:0] t;
		logic [64:0] diff;
		logic        ge;

		if (I >= FRAC_BITS) begin : g_num
			assign xbit = lo_s[k-1][I-FRAC_BITS];
		end else begin : g_zero
			assign xbit = 1'b0;
		end

		assign t    = {r_s[k-1], xbit};
		assign ge   = t >= {1'b0, d_s[k-1]};
		assign diff = t - {1'b0, d_s[k-1]};

		always_ff @(posedge clk) begin
			if (adv) begin
				r_s[k]   <= ge ? diff[63:0] : t[63:0];
				q_s[k]   <= {q_s[k-1][30:0], ge};
				d_s[k]   <= d_s[k-1];
				lo_s[k]  <= lo_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = q_s[DIV_STEPS];
	assign ovf = ovf_s[DIV_STEPS];

endmodule

`default_nettype wire

// ----- src/cau_sqrt.sv -----
// Pipelined integer square root: one root bit per stage.
`default_nettype none

module cau_sqrt import cau_pkg::*; (
	input  wire logic        clk,
	input  wire logic        adv,
	input  wire logic [63:0] val,
	output logic [31:0]      root
);

	logic [63:0] v_s   [0:SQRT_STEPS];
	logic [33:0] rem_s [0:SQRT_STEPS];
	logic [31:0] q_s   [0:SQRT_STEPS];

	// Entry stage: capture the radicand and clear the partial root.
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s[0]   <= val;
			rem_s[0] <= '0;
			q_s[0]   <= '0;
		end
	end

	// Bring down two radicand bits and try the next root bit.
	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
		localparam int I = SQRT_STEPS - k;
		logic [35:0] remx;
		logic [35:0] trial;
		logic [35:0] diff;
		logic        ge;

		assign remx  = {rem_s[k-1], v_s[k-1][2*I+1:2*I]};
		assign trial = {2'b0, q_s[k-1], 2'b01};
		assign ge    = remx >= trial;
		assign diff  = remx - trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? diff[33:0] : remx[33:0];
				q_s[k]   <= {q_s[k-1][30:0], ge};
				v_s[k]   <= v_s[k-1];
			end
		end
	end

	assign root = q_s[SQRT_STEPS];

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the complex arithmetic unit with an internal result predictor.
`timescale 1ns / 1ps

module testbench import cau_pkg::*;;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [3:0]        kind;
	logic signed [31:0] a_re, a_im, b_re, b_im, scale_factor;
	logic [30:0]       tolerance;
	logic              out_valid;
	logic              out_stall;
	logic signed [31:0] result_re, result_im;
	logic              result_flag;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	res_t pending_results[$];
	int   mismatches;
	int   results_checked;
	int   items_sent;
	int   cycles;
	bit   steady_flow;

	complex_arithmetic_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.scale_factor(scale_factor), .tolerance(tolerance),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_re(result_re), .result_im(result_im), .result_flag(result_flag)
	);

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Clamp a wide signed value to the word range.
	function automatic word_t clamp_word(input logic signed [127:0] v);
		if (v > 128'sd2147483647) begin
			return WORD_MAX;
		end else if (v < -128'sd2147483648) begin
			return WORD_MIN;
		end
		return v[31:0];
	endfunction

	// Truncated integer square root of a 64-bit value.
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] rem, root, b;
		rem = v;
		root = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// Truncated quotient of num * 2^16 / den, saturated; den is nonzero.
	function automatic word_t fixed_quotient(input logic signed [127:0] num,
			input logic [127:0] den);
		logic [127:0] mag, q;
		logic signed [127:0] val;
		mag = num < 0 ? -num : num;
		q = (mag << FRAC_BITS) / den;
		val = num < 0 ? -$signed(q) : $signed(q);
		return clamp_word(val);
	endfunction

	// Expected result of one item.
	function automatic res_t predict_result(input logic [3:0] k,
			input logic signed [31:0] xr, xi, yr, yi, f, input logic [30:0] tol);
		res_t r;
		logic signed [127:0] ar, ai, br, bi, sf, den, dr, di;
		ar = xr; ai = xi; br = yr; bi = yi; sf = f;
		r = '0;
		case (k)
			OP_ADD: begin
				r.re = clamp_word(ar + br);
				r.im = clamp_word(ai + bi);
			end
			OP_SUB: begin
				r.re = clamp_word(ar - br);
				r.im = clamp_word(ai - bi);
			end
			OP_MUL: begin
				r.re = clamp_word((ar * br - ai * bi) >>> FRAC_BITS);
				r.im = clamp_word((ar * bi + ai * br) >>> FRAC_BITS);
			end
			OP_DIV: begin
				den = br * br + bi * bi;
				if (den != 0) begin
					r.re = fixed_quotient(ar * br + ai * bi, den);
					r.im = fixed_quotient(ai * br - ar * bi, den);
				end
			end
			OP_SCALE: begin
				r.re = clamp_word((ar * sf) >>> FRAC_BITS);
				r.im = clamp_word((ai * sf) >>> FRAC_BITS);
			end
			OP_CONJ: begin
				r.re = clamp_word(ar);
				r.im = clamp_word(-ai);
			end
			OP_NEG: begin
				r.re = clamp_word(-ar);
				r.im = clamp_word(-ai);
			end
			OP_MAG: begin
				den = ar * ar + ai * ai;
				r.re = clamp_word($signed({64'd0, int_sqrt(den[63:0])}));
			end
			OP_MAGSQ: r.re = clamp_word((ar * ar + ai * ai) >>> FRAC_BITS);
			OP_ISZERO: r.flag = (xr == 0 && xi == 0);
			OP_ISEQ: r.flag = (xr == yr && xi == yi);
			OP_ISNEAR: begin
				dr = ar - br;
				di = ai - bi;
				if (dr < 0) dr = -dr;
				if (di < 0) di = -di;
				r.flag = (dr <= tol && di <= tol);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// Operand with a bias toward extremes and small magnitudes.
	function automatic logic signed [31:0] pick_word();
		logic signed [31:0] w;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 5))
					0: w = WORD_MAX;
					1: w = WORD_MIN;
					2: w = 0;
					3: w = -1;
					4: w = 32'sh0001_0000;
					default: w = -32'sh0001_0000;
				endcase
			end
			1, 2: w = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// Send one item; each cycle before it idles at random unless the flow is steady.
	task automatic send_item(input logic [3:0] k, input logic signed [31:0] xr, xi, yr, yi,
			input logic signed [31:0] f, input logic [30:0] tol);
		while (!steady_flow && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		a_re <= xr; a_im <= xi; b_re <= yr; b_im <= yi;
		scale_factor <= f;
		tolerance <= tol;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_result(k, xr, xi, yr, yi, f, tol));
		items_sent++;
	endtask

	// One random item; comparison opcodes often get matching or nearby operands.
	task automatic send_random_item();
		logic [3:0] k;
		logic signed [31:0] xr, xi, yr, yi;
		logic [30:0] tol;
		k = 4'($urandom_range(0, 15));
		xr = pick_word(); xi = pick_word(); yr = pick_word(); yi = pick_word();
		tol = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1024));
		if ((k == OP_ISEQ || k == OP_ISNEAR) && $urandom_range(0, 1)) begin
			yr = xr + $signed($urandom_range(0, 2048)) - 1024;
			yi = xi + $signed($urandom_range(0, 2048)) - 1024;
		end
		if (k == OP_ISZERO && $urandom_range(0, 2) == 0) begin
			xr = 0;
			if ($urandom_range(0, 1)) xi = 0;
		end
		send_item(k, xr, xi, yr, yi, pick_word(), tol);
	endtask

	// Extremes of each field, every opcode and the special cases.
	task automatic test_directed();
		send_item(OP_ADD, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 0, 0);
		send_item(OP_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, 0, 0);
		send_item(OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0);
		send_item(OP_MUL, -1, 0, 1, 0, 0, 0);
		send_item(OP_DIV, 32'sh0001_0000, 0, 0, 0, 0, 0);
		send_item(OP_DIV, WORD_MAX, WORD_MAX, 1, 0, 0, 0);
		send_item(OP_DIV, WORD_MIN, 7, WORD_MIN, WORD_MIN, 0, 0);
		send_item(OP_DIV, -5, 3, 0, 32'sh0002_0000, 0, 0);
		send_item(OP_SCALE, WORD_MAX, WORD_MIN, 0, 0, WORD_MIN, 0);
		send_item(OP_SCALE, -3, 3, 0, 0, 32'sh0000_8000, 0);
		send_item(OP_CONJ, WORD_MIN, WORD_MIN, 0, 0, 0, 0);
		send_item(OP_NEG, WORD_MIN, WORD_MAX, 0, 0, 0, 0);
		send_item(OP_MAG, WORD_MIN, WORD_MIN, 0, 0, 0, 0);
		send_item(OP_MAG, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0);
		send_item(OP_MAGSQ, WORD_MIN, WORD_MAX, 0, 0, 0, 0);
		send_item(OP_ISZERO, 0, 0, 5, 5, 0, 0);
		send_item(OP_ISZERO, 0, 1, 0, 0, 0, 0);
		send_item(OP_ISEQ, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 0, 0);
		send_item(OP_ISEQ, 1, 2, 1, 3, 0, 0);
		send_item(OP_ISNEAR, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, 31'h7FFF_FFFF, 0);
		send_item(OP_ISNEAR, 100, -100, 110, -90, 0, 10);
		send_item(OP_ISNEAR, 100, -100, 111, -90, 0, 10);
		send_item(OP_ISNEAR, WORD_MIN, 0, WORD_MAX, 0, 0, 31'h7FFF_FFFF);
		send_item(4'd12, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 31'h7FFF_FFFF);
		send_item(4'd15, -1, -1, -1, -1, -1, 31'h7FFF_FFFF);
	endtask

	// Random items with idle gaps and output stalls.
	task automatic test_random_mix(input int count);
		steady_flow = 1'b0;
		repeat (count) send_random_item();
	endtask

	// Back-to-back items with no idling on either side.
	task automatic test_steady_stream(input int count);
		steady_flow = 1'b1;
		repeat (count) send_random_item();
		steady_flow = 1'b0;
	endtask

	// Output stall, driven high at random with a chance of 29 in 100 outside steady stretches.
	always @(posedge clk) begin
		out_stall <= !steady_flow && ($urandom_range(0, 99) < 29);
	end

	// Compare every accepted result with the oldest expected one.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result re=%0d im=%0d flag=%0d",
						result_re, result_im, result_flag);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (want.re !== result_re || want.im !== result_im ||
						want.flag !== result_flag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected re=%0d im=%0d flag=%0d, got re=%0d im=%0d flag=%0d",
							want.re, want.im, want.flag,
							result_re, result_im, result_flag);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		results_checked = 0;
		items_sent = 0;
		cycles = 0;
		steady_flow = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		kind <= '0;
		a_re <= '0; a_im <= '0; b_re <= '0; b_im <= '0;
		scale_factor <= '0;
		tolerance <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(1200);
		test_steady_stream(500);
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items over all opcodes and unused kinds, checked %0d results",
			items_sent, results_checked);
		$display("mismatches: %0d", mismatches + pending_results.size());
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
